// File: rtl/ordered_sequence_store_unit_macros.svh
// Assertion macros for the ordered sequence store unit.
// Used by the controller and the datapath; no other dependencies.
`ifndef ORDERED_SEQUENCE_STORE_UNIT_MACROS_SVH
`define ORDERED_SEQUENCE_STORE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define OSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define OSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define OSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OSS_ASSERT(lbl, prop, msg)
`define OSS_ASSERT_IMP(lbl, ante, cons, msg)
`define OSS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/oss_pkg.sv
// Shared types and constants of the ordered sequence store unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package oss_pkg;

  localparam int unsigned CAPACITY_DEF = 256;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned STS_W     = 2;
  localparam int unsigned CNT_OUT_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_DELETE     = 3'd5,
    CMD_FIND       = 3'd6
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_DONE      = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } oss_req_t;

  typedef struct packed {
    logic [STS_W-1:0]     status;
    logic                 found;
    logic [CNT_OUT_W-1:0] count;
  } oss_rsp_t;

  typedef enum logic [2:0] {
    RD_HOLD, RD_ZERO, RD_ONE, RD_CNT_M1, RD_INC, RD_DEC
  } rd_op_e;

  typedef enum logic [2:0] {
    WR_HOLD, WR_ZERO, WR_CNT, WR_INC, WR_DEC
  } wr_op_e;

  typedef enum logic [1:0] {
    WD_RDATA, WD_VALUE, WD_ZERO
  } wd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC, CNT_POS1
  } cnt_op_e;

  // Controller to datapath
  typedef struct packed {
    logic    req_load;
    rd_op_e  rd_op;
    wr_op_e  wr_op;
    logic    mem_we;
    wd_sel_e wd_sel;
    cnt_op_e cnt_op;
    logic    res_load;
    status_e res_status;
    logic    res_found;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cnt_zero;
    logic             cnt_one;
    logic             full;
    logic             pos_inside;
    logic             pos_fits;
    logic             match;
    logic             scan_last;
    logic             shl_last;
    logic             shr_last;
    logic             fill_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/oss_dp.sv
// Datapath of the ordered sequence store: entry memory, walk pointers,
// entry count, request latch and result register. Depends on oss_pkg.
`default_nettype none
`include "ordered_sequence_store_unit_macros.svh"

module oss_dp #(
  parameter int unsigned CAPACITY = oss_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oss_pkg::oss_req_t req_i,
  input  oss_pkg::dp_cmd_t  cmd_i,
  output oss_pkg::dp_sts_t  sts_o,
  output oss_pkg::oss_rsp_t rsp_o
);
  import oss_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_q;
  logic [VAL_W-1:0] value_q;
  logic [CMD_W-1:0] cmd_q;
  logic [PW-1:0]    pos_q, pos_d;
  logic [PW-1:0]    rd_q, rd_d;
  logic [PW-1:0]    wr_q, wr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [VAL_W-1:0] wdata;
  logic [PW-1:0]    cntp;
  oss_rsp_t         rsp_q;

  assign cntp = PW'(cnt_q);

  // Push front is an insert at the head, push back an insert at the tail.
  always_comb begin
    case (req_i.cmd)
      CMD_PUSH_FRONT: pos_d = '0;
      CMD_PUSH_BACK:  pos_d = cntp;
      default:        pos_d = PW'(req_i.position);
    endcase
  end

  always_comb begin
    case (cmd_i.rd_op)
      RD_ZERO:   rd_d = '0;
      RD_ONE:    rd_d = PW'(1);
      RD_CNT_M1: rd_d = cntp - PW'(1);
      RD_INC:    rd_d = rd_q + PW'(1);
      RD_DEC:    rd_d = rd_q - PW'(1);
      default:   rd_d = rd_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_op)
      WR_ZERO: wr_d = '0;
      WR_CNT:  wr_d = cntp;
      WR_INC:  wr_d = wr_q + PW'(1);
      WR_DEC:  wr_d = wr_q - PW'(1);
      default: wr_d = wr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC:  cnt_d = cnt_q + CW'(1);
      CNT_DEC:  cnt_d = cnt_q - CW'(1);
      CNT_POS1: cnt_d = CW'(pos_q + PW'(1));
      default:  cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wd_sel)
      WD_VALUE: wdata = value_q;
      WD_ZERO:  wdata = '0;
      default:  wdata = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      cmd_q   <= req_i.cmd;
      value_q <= req_i.value;
      pos_q   <= pos_d;
    end
    rd_q <= rd_d;
    wr_q <= wr_d;
    if (cmd_i.res_load) begin
      rsp_q.status <= cmd_i.res_status;
      rsp_q.found  <= cmd_i.res_found;
      rsp_q.count  <= CNT_OUT_W'(cnt_q);
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[wr_q[AW-1:0]] <= wdata;
    end
    rdata_q <= mem[rd_q[AW-1:0]];
  end

  always_comb begin
    sts_o.cmd        = cmd_q;
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.cnt_one    = (cnt_q == CW'(1));
    sts_o.full       = (cnt_q == CW'(CAPACITY));
    sts_o.pos_inside = (pos_q < cntp);
    sts_o.pos_fits   = (pos_q < PW'(CAPACITY));
    sts_o.match      = (rdata_q == value_q);
    sts_o.scan_last  = (wr_q == cntp - PW'(1));
    sts_o.shl_last   = (({1'b0, wr_q} + (PW+1)'(2)) == {1'b0, cntp});
    sts_o.shr_last   = ({1'b0, wr_q} == ({1'b0, pos_q} + (PW+1)'(1)));
    sts_o.fill_last  = (wr_q == pos_q);
  end

  assign rsp_o = rsp_q;

  `OSS_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY), "entry count above capacity")
  `OSS_ASSERT_IMP(a_we_range, cmd_i.mem_we, wr_q < PW'(CAPACITY), "write past last entry")
  `OSS_ASSERT_IMP(a_dec_nonempty, cmd_i.cnt_op == CNT_DEC, cnt_q != '0, "count underflow")

endmodule

`default_nettype wire

// File: rtl/oss_ctrl.sv
// Controller of the ordered sequence store: sequences scans and shifts
// through the datapath and owns both handshakes. Depends on oss_pkg.
`default_nettype none
`include "ordered_sequence_store_unit_macros.svh"

module oss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  oss_pkg::dp_sts_t sts_i,
  output oss_pkg::dp_cmd_t cmd_o
);
  import oss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_PRIME,
    S_SCAN,
    S_SHL_PRIME,
    S_SHL,
    S_SHR_PRIME,
    S_SHR,
    S_SHR_PUT,
    S_FILL,
    S_REPORT
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    found_q, found_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o.req_load   = 1'b0;
    cmd_o.rd_op      = RD_HOLD;
    cmd_o.wr_op      = WR_HOLD;
    cmd_o.mem_we     = 1'b0;
    cmd_o.wd_sel     = WD_RDATA;
    cmd_o.cnt_op     = CNT_HOLD;
    cmd_o.res_load   = 1'b0;
    cmd_o.res_status = st_q;
    cmd_o.res_found  = found_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          st_d           = STS_DONE;
          found_d        = 1'b0;
          state_d        = S_DECODE;
        end
      end

      S_DECODE: begin
        case (sts_i.cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
            if (sts_i.pos_inside) begin
              if (sts_i.full) begin
                st_d    = STS_FULL;
                state_d = S_REPORT;
              end else begin
                cmd_o.rd_op = RD_CNT_M1;
                cmd_o.wr_op = WR_CNT;
                state_d     = S_SHR_PRIME;
              end
            end else if (!sts_i.pos_fits) begin
              st_d    = STS_FULL;
              state_d = S_REPORT;
            end else begin
              cmd_o.wr_op = WR_CNT;
              state_d     = S_FILL;
            end
          end
          CMD_POP_FRONT: begin
            if (sts_i.cnt_zero) begin
              st_d    = STS_EMPTY;
              state_d = S_REPORT;
            end else if (sts_i.cnt_one) begin
              cmd_o.cnt_op = CNT_DEC;
              state_d      = S_REPORT;
            end else begin
              cmd_o.rd_op = RD_ONE;
              cmd_o.wr_op = WR_ZERO;
              state_d     = S_SHL_PRIME;
            end
          end
          CMD_POP_BACK: begin
            if (sts_i.cnt_zero) begin
              st_d = STS_EMPTY;
            end else begin
              cmd_o.cnt_op = CNT_DEC;
            end
            state_d = S_REPORT;
          end
          CMD_DELETE, CMD_FIND: begin
            if (sts_i.cnt_zero) begin
              st_d    = STS_NOT_FOUND;
              state_d = S_REPORT;
            end else begin
              cmd_o.rd_op = RD_ZERO;
              cmd_o.wr_op = WR_ZERO;
              state_d     = S_SCAN_PRIME;
            end
          end
          default: begin
            state_d = S_REPORT;
          end
        endcase
      end

      S_SCAN_PRIME: begin
        cmd_o.rd_op = RD_INC;
        state_d     = S_SCAN;
      end

      // Read data holds the entry at the write pointer; read runs one ahead.
      S_SCAN: begin
        if (sts_i.match) begin
          found_d = 1'b1;
          if (sts_i.cmd == CMD_FIND) begin
            state_d = S_REPORT;
          end else if (sts_i.scan_last) begin
            cmd_o.cnt_op = CNT_DEC;
            state_d      = S_REPORT;
          end else begin
            // The read under way fetches the entry that closes the gap.
            cmd_o.rd_op = RD_INC;
            state_d     = S_SHL;
          end
        end else if (sts_i.scan_last) begin
          st_d    = STS_NOT_FOUND;
          state_d = S_REPORT;
        end else begin
          cmd_o.rd_op = RD_INC;
          cmd_o.wr_op = WR_INC;
        end
      end

      S_SHL_PRIME: begin
        cmd_o.rd_op = RD_INC;
        state_d     = S_SHL;
      end

      S_SHL: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wd_sel = WD_RDATA;
        if (sts_i.shl_last) begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_REPORT;
        end else begin
          cmd_o.rd_op = RD_INC;
          cmd_o.wr_op = WR_INC;
        end
      end

      S_SHR_PRIME: begin
        cmd_o.rd_op = RD_DEC;
        state_d     = S_SHR;
      end

      S_SHR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wd_sel = WD_RDATA;
        cmd_o.wr_op  = WR_DEC;
        if (sts_i.shr_last) begin
          state_d = S_SHR_PUT;
        end else begin
          cmd_o.rd_op = RD_DEC;
        end
      end

      S_SHR_PUT: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wd_sel = WD_VALUE;
        cmd_o.cnt_op = CNT_INC;
        state_d      = S_REPORT;
      end

      // Pad with zeros up to the insert slot, then drop the value in.
      S_FILL: begin
        cmd_o.mem_we = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.wd_sel = WD_VALUE;
          cmd_o.cnt_op = CNT_POS1;
          state_d      = S_REPORT;
        end else begin
          cmd_o.wd_sel = WD_ZERO;
          cmd_o.wr_op  = WR_INC;
        end
      end

      S_REPORT: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= STS_DONE;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  `OSS_ASSERT_IMP(a_shl_cmd, state_q == S_SHL,
                  sts_i.cmd == CMD_POP_FRONT || sts_i.cmd == CMD_DELETE,
                  "left shift outside pop front or delete")
  `OSS_ASSERT_NXT(a_report_valid, state_q == S_REPORT && out_free,
                  out_valid_q && state_q == S_IDLE,
                  "result not presented after report")
  `OSS_ASSERT_IMP(a_found_done, found_q && state_q == S_REPORT, st_q == STS_DONE,
                  "match reported with error status")

endmodule

`default_nettype wire

// File: rtl/ordered_sequence_store_unit.sv
// Ordered sequence store: a bounded list of signed 32-bit values, up to CAPACITY
// entries, kept in a single memory with one write and one registered read port.
// Each request (push/pop front or back, insert at a position, delete or find
// a value) returns one result with status, found flag and the low 9 bits of
// the entry count. Pop back and requests answered without touching the memory
// go straight from decode to the result. Every other request walks the memory
// one entry per cycle: an insert inside the list shifts the entries from the
// end down to the position, an insert past the end pads with zeros up to the
// position, a find scans up to the matching entry, and a delete also shifts
// the entries after it left. A result waits until the previous one has left
// the output. One request is in flight at a time; a new one is taken while the
// previous result still waits on the output.
// Depends on oss_pkg, oss_ctrl and oss_dp.
`default_nettype none

module ordered_sequence_store_unit #(
  parameter int unsigned CAPACITY = oss_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  oss_pkg::oss_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output oss_pkg::oss_rsp_t out_rsp_o
);
  import oss_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  oss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  oss_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts),
    .rsp_o  (out_rsp_o)
  );

endmodule

`default_nettype wire
